// File: sv/vit_pkg.sv
// Shared types and constants for the value interning table.
package vit_pkg;

  // Width of an interned value.
  localparam int unsigned VALUE_W = 32;

  // Width of the id field of a result.
  localparam int unsigned ID_W = 7;

  // Fields of one result item.
  typedef struct packed {
    logic [ID_W-1:0] id_out;
    logic            was_new;
    logic            table_full;
  } vit_result_t;

endpackage

// File: sv/vit_if.sv
// Valid/ready channel interfaces for the value interning table.
interface vit_value_if;
  import vit_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface vit_result_if;
  import vit_pkg::*;

  logic            valid;
  logic            ready;
  logic [ID_W-1:0] id_out;
  logic            was_new;
  logic            table_full;

  modport source (output valid, output id_out, output was_new, output table_full, input ready);
  modport sink (input valid, input id_out, input was_new, input table_full, output ready);
endinterface

// File: sv/value_interning_table.sv
// Value interning table: maps 32-bit values to ids in order of first appearance.
//
//   channel     dir  payload                          handshake
//   item_in     in   value (32 b, signed)             valid/ready
//   result_out  out  id_out (7 b), was_new, table_full valid/ready
//
// The stored values are scanned one per cycle through the single registered read
// port of the value memory. The result is loaded once the scan ends, and the next
// item can be taken in the cycle after the result is loaded; only one item is
// handled at a time. A hit ends the scan early.
// Reset clears the entry count and the control state; the value memory is not
// cleared, as only entries below the count are ever read.
// A waiting result sits in the output register while the next item is taken;
// the block stalls at the end of that next item until the result is taken.
module value_interning_table #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input logic          clk,
  input logic          rst,
  vit_value_if.sink    item_in,
  vit_result_if.source result_out
);
  import vit_pkg::*;

  localparam int unsigned ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDW    = (CNT_W > ID_W) ? CNT_W : ID_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t               state;
  logic [VALUE_W-1:0]   probe;
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     rd_cnt;
  logic [ADDR_W-1:0]    cmp_idx;
  logic                 cmp_vld;
  logic                 hit;
  logic [ADDR_W-1:0]    hit_pos;
  logic [VALUE_W-1:0]   rdata;

  // Value memory: one write port, one registered read port.
  logic [VALUE_W-1:0]   mem [TABLE_DEPTH];

  logic                 rd_en;
  logic                 match;
  logic                 load;
  logic                 wr_en;
  logic                 is_full;
  logic [IDW-1:0]       id_wide;
  vit_result_t          res;

  assign item_in.ready = (state == S_IDLE);

  // Compare the data read in the previous cycle against the probe.
  assign match = cmp_vld && (rdata == probe);

  // Keep issuing reads until every stored entry has been fetched or a hit is found.
  assign rd_en = (state == S_SCAN) && (rd_cnt != count) && !match;

  // The result register is free when empty or being emptied this cycle.
  assign load    = (state == S_FINISH) && (!result_out.valid || result_out.ready);
  assign is_full = (count == CNT_W'(TABLE_DEPTH));
  assign wr_en   = load && !hit && !is_full;

  // Build the result item from the scan outcome.
  always_comb begin
    if (hit) begin
      id_wide = IDW'(hit_pos) + IDW'(1);
    end else if (!is_full) begin
      id_wide = IDW'(count) + IDW'(1);
    end else begin
      id_wide = '0;
    end
    res.id_out     = id_wide[ID_W-1:0];
    res.was_new    = !hit && !is_full;
    res.table_full = !hit && is_full;
  end

  // Memory read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_cnt[ADDR_W-1:0]];
    end
  end

  // Memory write port: appends a missed value at the current count.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[ADDR_W-1:0]] <= probe;
    end
  end

  // Sequencer, entry count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      cmp_vld          <= 1'b0;
      hit              <= 1'b0;
      result_out.valid <= 1'b0;
    end else begin
      // The output register fills on a load and empties on a transfer.
      if (load) begin
        result_out.valid <= 1'b1;
      end else if (result_out.valid && result_out.ready) begin
        result_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (item_in.valid) begin
            probe   <= item_in.value;
            rd_cnt  <= '0;
            cmp_vld <= 1'b0;
            hit     <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          cmp_vld <= rd_en;
          if (rd_en) begin
            cmp_idx <= rd_cnt[ADDR_W-1:0];
            rd_cnt  <= rd_cnt + CNT_W'(1);
          end
          if (match) begin
            hit     <= 1'b1;
            hit_pos <= cmp_idx;
            state   <= S_FINISH;
          end else if (!cmp_vld && (rd_cnt == count)) begin
            // Every stored entry has been compared without a hit.
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          cmp_vld <= 1'b0;
          if (load) begin
            result_out.id_out     <= res.id_out;
            result_out.was_new    <= res.was_new;
            result_out.table_full <= res.table_full;
            if (wr_en) begin
              count <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The entry count never passes the table depth.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A result is never both new and an overflow.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> !(result_out.was_new && result_out.table_full))
    else $error("result marked both new and full");

  // A new entry advances the count by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not advance the entry count");

  // Reads only ever touch entries that were written.
  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_cnt < count)
    else $error("read of an unwritten entry");

endmodule
